>>> src/pebuf_pkg.sv
// ---------------------------------------------------------------------------
// pebuf_pkg - shared definitions for the priority evicting event buffer
// Command and item codes, entry layout and default sizing.
// ---------------------------------------------------------------------------
`default_nettype none

package pebuf_pkg;

	localparam int DEF_MAX_EVENTS    = 32;
	localparam int DEF_PAYLOAD_BYTES = 256;
	localparam int DEF_LOWEST_LEVEL  = 0;
	localparam int DEF_HIGHEST_LEVEL = 2;

	localparam int RECORD_SIZE = 13;
	localparam int HEADER_SIZE = 16;

	// level is clamped to the highest level; the 3-bit field holds at most 7
	localparam int LVL_W = 3;
	localparam int ORD_W = 16;

	typedef enum logic [1:0] {
		CMD_RECORD  = 2'd0,
		CMD_PUBLISH = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_RECORD  = 2'd1,
		KIND_SUMMARY = 2'd2
	} item_kind_t;

	typedef struct packed {
		logic [31:0]      arg_b;
		logic [31:0]      arg_a;
		logic [ORD_W-1:0] order;
		logic [7:0]       code;
		logic [LVL_W-1:0] level;
		logic [15:0]      line;
		logic [7:0]       source;
	} entry_t;

endpackage

`default_nettype wire

>>> src/priority_evicting_event_buffer.sv
// ---------------------------------------------------------------------------
// priority_evicting_event_buffer - bounded event store with level eviction
// Records events, publishes them by level, and clears on command.
// ---------------------------------------------------------------------------
// Usage:
//   The slave stream carries one command per transaction: s_tuser holds the
//   command, s_tdata the event fields and the publish sequence number.
//   The master stream returns result transactions; m_tuser gives the item
//   kind and m_tlast marks the final item of a command.
//   Record, clear and unused commands answer with one acknowledgement. With
//   the store full, the eviction scan reads every entry once through the
//   single read port. Publish scans the filled entries once per level and
//   stops early when the payload limit is reached; a summary item ends it.
//   One command is in work at a time; s_tready is high only when idle.
//   If the receiver stalls, the sequencer holds in place until the output
//   register is free again; nothing is lost.
//   Reset empties the store (fill count, drop and order counters to zero);
//   entry memory contents are not cleared, as only filled slots are read.
// ---------------------------------------------------------------------------
`default_nettype none

module priority_evicting_event_buffer #(
	parameter int MAX_EVENTS    = pebuf_pkg::DEF_MAX_EVENTS,
	parameter int PAYLOAD_BYTES = pebuf_pkg::DEF_PAYLOAD_BYTES,
	parameter int LOWEST_LEVEL  = pebuf_pkg::DEF_LOWEST_LEVEL,
	parameter int HIGHEST_LEVEL = pebuf_pkg::DEF_HIGHEST_LEVEL
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// source_id, line_number, severity, event_kind, first_arg, second_arg,
	// publish_seq
	input  wire  [135:0] s_tdata,
	// cmd
	input  wire  [1:0]   s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// rec_source, rec_line, rec_level, rec_code, rec_arg_a, rec_arg_b,
	// stored_count, dropped_total, records_sent, seq_echo, 2 zero bits
	output logic [159:0] m_tdata,
	// item_kind
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);
	import pebuf_pkg::*;

	localparam int IDX_W    = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int FILL_W   = $clog2(MAX_EVENTS + 1);
	localparam int MAX_SENT = (PAYLOAD_BYTES - HEADER_SIZE) / RECORD_SIZE;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACK,
		ST_EV_RD,
		ST_EV_CHK,
		ST_EV_WR,
		ST_PUB_RD,
		ST_PUB_CHK,
		ST_SUM
	} state_t;

	state_t            state_q;
	logic [FILL_W-1:0] fill_q;
	logic [15:0]       drop_q;
	logic [ORD_W-1:0]  order_q;
	logic [IDX_W-1:0]  idx_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [5:0]        sent_q;
	logic [31:0]       seq_q;
	entry_t            new_q;
	logic              found_q;
	logic [IDX_W-1:0]  best_q;
	logic [LVL_W-1:0]  best_lvl_q;
	logic [ORD_W-1:0]  best_ord_q;

	logic              wr_en_q;
	logic [IDX_W-1:0]  wr_addr_q;
	entry_t            wr_entry_q;
	entry_t            rd_entry;

	// output register
	logic              out_valid_q;
	item_kind_t        out_kind_q;
	entry_t            out_entry_q;
	logic [5:0]        out_stored_q;
	logic [15:0]       out_drop_q;
	logic [5:0]        out_recs_q;
	logic [31:0]       out_seq_q;
	logic              out_last_q;

	logic              out_free;
	logic              idx_last;
	logic [7:0]        sev;
	logic [LVL_W-1:0]  clamped;
	entry_t            in_entry;

	pebuf_store #(
		.DEPTH (MAX_EVENTS),
		.IDX_W (IDX_W)
	) u_store (
		.clk      (clk),
		.wr_en    (wr_en_q),
		.wr_addr  (wr_addr_q),
		.wr_entry (wr_entry_q),
		.rd_addr  (idx_q),
		.rd_entry (rd_entry)
	);

	assign out_free = !out_valid_q || m_tready;
	assign idx_last = ((FILL_W'(idx_q) + 1'b1) == fill_q);
	assign s_tready = (state_q == ST_IDLE);

	// clamp severity and build the new entry
	assign sev = s_tdata[31:24];
	always_comb begin
		if (int'(sev) > HIGHEST_LEVEL) begin
			clamped = LVL_W'(HIGHEST_LEVEL);
		end else if (int'(sev) < LOWEST_LEVEL) begin
			clamped = LVL_W'(LOWEST_LEVEL);
		end else begin
			clamped = sev[LVL_W-1:0];
		end
		in_entry.source = s_tdata[7:0];
		in_entry.line   = s_tdata[23:8];
		in_entry.level  = clamped;
		in_entry.code   = s_tdata[39:32];
		in_entry.order  = order_q;
		in_entry.arg_a  = s_tdata[71:40];
		in_entry.arg_b  = s_tdata[103:72];
	end

	// sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			drop_q      <= '0;
			order_q     <= '0;
			idx_q       <= '0;
			lvl_q       <= '0;
			sent_q      <= '0;
			found_q     <= 1'b0;
			wr_en_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_en_q <= 1'b0;
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q <= '0;
						case (s_tuser)
							CMD_RECORD: begin
								new_q   <= in_entry;
								order_q <= order_q + 1'b1;
								if (int'(fill_q) < MAX_EVENTS) begin
									wr_en_q    <= 1'b1;
									wr_addr_q  <= fill_q[IDX_W-1:0];
									wr_entry_q <= in_entry;
									fill_q     <= fill_q + 1'b1;
									state_q    <= ST_ACK;
								end else begin
									found_q <= 1'b0;
									state_q <= ST_EV_RD;
								end
							end
							CMD_PUBLISH: begin
								seq_q   <= s_tdata[135:104];
								lvl_q   <= LVL_W'(HIGHEST_LEVEL);
								sent_q  <= '0;
								state_q <= (fill_q == '0) ? ST_SUM : ST_PUB_RD;
							end
							CMD_CLEAR: begin
								fill_q  <= '0;
								drop_q  <= '0;
								order_q <= '0;
								state_q <= ST_ACK;
							end
							default: begin
								state_q <= ST_ACK;
							end
						endcase
					end
				end
				ST_ACK: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= KIND_ACK;
						out_entry_q  <= '0;
						out_stored_q <= 6'(fill_q);
						out_drop_q   <= drop_q;
						out_recs_q   <= '0;
						out_seq_q    <= '0;
						out_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_EV_RD: begin
					state_q <= ST_EV_CHK;
				end
				ST_EV_CHK: begin
					// keep the lowest level, then the lowest order, below the new level
					if (rd_entry.level < new_q.level &&
					    (!found_q || rd_entry.level < best_lvl_q ||
					     (rd_entry.level == best_lvl_q && rd_entry.order < best_ord_q))) begin
						found_q    <= 1'b1;
						best_q     <= idx_q;
						best_lvl_q <= rd_entry.level;
						best_ord_q <= rd_entry.order;
					end
					if (idx_last) begin
						state_q <= ST_EV_WR;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_EV_RD;
					end
				end
				ST_EV_WR: begin
					wr_en_q    <= found_q;
					wr_addr_q  <= best_q;
					wr_entry_q <= new_q;
					drop_q     <= drop_q + 1'b1;
					state_q    <= ST_ACK;
				end
				ST_PUB_RD: begin
					state_q <= ST_PUB_CHK;
				end
				ST_PUB_CHK: begin
					if (rd_entry.level == lvl_q && int'(sent_q) >= MAX_SENT) begin
						// payload full: stop for good
						state_q <= ST_SUM;
					end else if (rd_entry.level != lvl_q || out_free) begin
						if (rd_entry.level == lvl_q) begin
							out_valid_q  <= 1'b1;
							out_kind_q   <= KIND_RECORD;
							out_entry_q  <= rd_entry;
							out_stored_q <= 6'(fill_q);
							out_drop_q   <= drop_q;
							out_recs_q   <= '0;
							out_seq_q    <= '0;
							out_last_q   <= 1'b0;
							sent_q       <= sent_q + 1'b1;
						end
						// advance slot, then level
						if (idx_last) begin
							idx_q <= '0;
							if (int'(lvl_q) == LOWEST_LEVEL) begin
								state_q <= ST_SUM;
							end else begin
								lvl_q   <= lvl_q - 1'b1;
								state_q <= ST_PUB_RD;
							end
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_PUB_RD;
						end
					end
				end
				ST_SUM: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= KIND_SUMMARY;
						out_entry_q  <= '0;
						out_stored_q <= 6'(fill_q);
						out_drop_q   <= drop_q;
						out_recs_q   <= sent_q;
						out_seq_q    <= seq_q;
						out_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// drive the master stream
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_seq_q, out_recs_q, out_drop_q, out_stored_q,
	                   out_entry_q.arg_b, out_entry_q.arg_a, out_entry_q.code,
	                   out_entry_q.level[1:0], out_entry_q.line, out_entry_q.source};

endmodule

`default_nettype wire

>>> src/pebuf_store.sv
// ---------------------------------------------------------------------------
// pebuf_store - event entry memory
// One write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module pebuf_store #(
	parameter int DEPTH = pebuf_pkg::DEF_MAX_EVENTS,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                    clk,
	input  wire                    wr_en,
	input  wire [IDX_W-1:0]        wr_addr,
	input  wire pebuf_pkg::entry_t wr_entry,
	input  wire [IDX_W-1:0]        rd_addr,
	output pebuf_pkg::entry_t      rd_entry
);
	import pebuf_pkg::*;

	entry_t mem_q [DEPTH];

	// write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_entry <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

>>> test/pebuf_checker.sv
// ---------------------------------------------------------------------------
// pebuf_checker - scoreboard for the priority evicting event buffer
// Watches both streams, keeps a shadow of the event store, predicts every
// result transaction and compares it field by field in arrival order.
// ---------------------------------------------------------------------------
`default_nettype none

module pebuf_checker
	import pebuf_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	input  wire          s_tready,
	input  wire  [135:0] s_tdata,
	input  wire  [1:0]   s_tuser,
	input  wire          m_tvalid,
	input  wire          m_tready,
	input  wire  [159:0] m_tdata,
	input  wire  [1:0]   m_tuser,
	input  wire          m_tlast,
	output int           fail_count,
	output int           outstanding,
	output int           evictions
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bit [1:0]  kind;
		bit [7:0]  src;
		bit [15:0] line;
		bit [1:0]  lvl;
		bit [7:0]  code;
		bit [31:0] arg_a;
		bit [31:0] arg_b;
		bit [5:0]  stored;
		bit [15:0] dropped;
		bit [5:0]  recs;
		bit [31:0] seq;
		bit        last;
	} result_t;

	typedef struct {
		bit [7:0]  src;
		bit [15:0] line;
		bit [2:0]  lvl;
		bit [7:0]  code;
		bit [15:0] order;
		bit [31:0] arg_a;
		bit [31:0] arg_b;
	} slot_t;

	slot_t     store [DEF_MAX_EVENTS];
	int        fill;
	bit [15:0] drops;
	bit [15:0] order_ctr;
	result_t   results_due [$];

	// Print one mismatch line and count it
	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic result_t blank_result();
		result_t r;
		r = '{default: '0};
		r.stored  = fill[5:0];
		r.dropped = drops;
		return r;
	endfunction

	// Store an event: append, evict the weakest lower-level entry, or drop
	function automatic void record_event(bit [135:0] d);
		slot_t e;
		int    best;
		best      = -1;
		e.src     = d[7:0];
		e.line    = d[23:8];
		e.lvl     = (d[31:24] > DEF_HIGHEST_LEVEL) ? DEF_HIGHEST_LEVEL[2:0] : d[26:24];
		e.code    = d[39:32];
		e.arg_a   = d[71:40];
		e.arg_b   = d[103:72];
		e.order   = order_ctr;
		order_ctr = order_ctr + 16'd1;
		if (fill < DEF_MAX_EVENTS) begin
			store[fill] = e;
			fill++;
			return;
		end
		for (int i = 0; i < fill; i++) begin
			if (store[i].lvl >= e.lvl)
				continue;
			if (best < 0 || store[i].lvl < store[best].lvl ||
			    (store[i].lvl == store[best].lvl && store[i].order < store[best].order))
				best = i;
		end
		if (best >= 0) begin
			store[best] = e;
			evictions++;
		end
		drops = drops + 16'd1;
	endfunction

	// Work out every result transaction that one command causes
	function automatic void predict_command(cmd_t cmd, bit [135:0] d);
		result_t r;
		int      sent;
		bit      stop;
		sent = 0;
		stop = 0;
		case (cmd)
			CMD_PUBLISH: begin
				for (int lv = DEF_HIGHEST_LEVEL; lv >= DEF_LOWEST_LEVEL && !stop; lv--) begin
					for (int i = 0; i < fill; i++) begin
						if (store[i].lvl != lv)
							continue;
						if (HEADER_SIZE + RECORD_SIZE * (sent + 1) > DEF_PAYLOAD_BYTES) begin
							stop = 1;
							break;
						end
						r       = blank_result();
						r.kind  = KIND_RECORD;
						r.src   = store[i].src;
						r.line  = store[i].line;
						r.lvl   = store[i].lvl[1:0];
						r.code  = store[i].code;
						r.arg_a = store[i].arg_a;
						r.arg_b = store[i].arg_b;
						results_due.push_back(r);
						sent++;
					end
				end
				r      = blank_result();
				r.kind = KIND_SUMMARY;
				r.recs = sent[5:0];
				r.seq  = d[135:104];
				r.last = 1'b1;
				results_due.push_back(r);
			end
			default: begin
				if (cmd == CMD_RECORD)
					record_event(d);
				else if (cmd == CMD_CLEAR) begin
					fill      = 0;
					drops     = '0;
					order_ctr = '0;
				end
				r      = blank_result();
				r.kind = KIND_ACK;
				r.last = 1'b1;
				results_due.push_back(r);
			end
		endcase
	endfunction

	// Compare one result transaction with the oldest prediction
	task automatic compare_result();
		result_t w;
		if (results_due.size() == 0) begin
			report("unexpected transaction", m_tdata[63:0], 0);
			return;
		end
		w = results_due.pop_front();
		if (m_tuser        != w.kind)    report("item_kind", m_tuser, w.kind);
		if (m_tdata[7:0]   != w.src)     report("rec_source", m_tdata[7:0], w.src);
		if (m_tdata[23:8]  != w.line)    report("rec_line", m_tdata[23:8], w.line);
		if (m_tdata[25:24] != w.lvl)     report("rec_level", m_tdata[25:24], w.lvl);
		if (m_tdata[33:26] != w.code)    report("rec_code", m_tdata[33:26], w.code);
		if (m_tdata[65:34] != w.arg_a)   report("rec_arg_a", m_tdata[65:34], w.arg_a);
		if (m_tdata[97:66] != w.arg_b)   report("rec_arg_b", m_tdata[97:66], w.arg_b);
		if (m_tdata[103:98] != w.stored) report("stored_count", m_tdata[103:98], w.stored);
		if (m_tdata[119:104] != w.dropped)
			report("dropped_total", m_tdata[119:104], w.dropped);
		if (m_tdata[125:120] != w.recs)  report("records_sent", m_tdata[125:120], w.recs);
		if (m_tdata[157:126] != w.seq)   report("seq_echo", m_tdata[157:126], w.seq);
		if (m_tlast        != w.last)    report("last", m_tlast, w.last);
	endtask

	// Track both channels on every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill        = 0;
			drops       = '0;
			order_ctr   = '0;
			fail_count  = 0;
			evictions   = 0;
			outstanding = 0;
			results_due.delete();
		end else begin
			if (s_tvalid && s_tready)
				predict_command(cmd_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready)
				compare_result();
			outstanding = results_due.size();
		end
	end

	// Report anything still awaited when the run closes
	task automatic close_out();
		if (results_due.size() != 0)
			report("results never delivered", results_due.size(), 0);
	endtask

endmodule

`default_nettype wire

>>> test/tb_priority_evicting_event_buffer.sv
// ---------------------------------------------------------------------------
// tb_priority_evicting_event_buffer - regression for the event buffer
// Drives directed and random record, publish, clear and unused commands with
// random gaps and back-pressure; the checker scores every result.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_priority_evicting_event_buffer;
	timeunit 1ns;
	timeprecision 1ps;
	import pebuf_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [159:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	int fail_count;
	int outstanding;
	int evictions;
	int sent_by_cmd [4];
	bit hold_off_req;
	bit calm_sender;

	priority_evicting_event_buffer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	pebuf_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.outstanding(outstanding),
		.evictions  (evictions)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one command and hold it until the transaction completes
	task automatic issue(cmd_t cmd, bit [7:0] src, bit [15:0] line, bit [7:0] sev,
	                     bit [7:0] code, bit [31:0] arg_a, bit [31:0] arg_b,
	                     bit [31:0] seq);
		int g;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {seq, arg_b, arg_a, code, sev, line, src};
		do
			@(posedge clk);
		while (!s_tready);
		sent_by_cmd[cmd]++;
		g = calm_sender ? 0 : gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic random_event(cmd_t cmd);
		bit [7:0] sev;
		sev = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		issue(cmd, 8'($urandom), 16'($urandom), sev, 8'($urandom), $urandom, $urandom,
		      $urandom);
	endtask

	// Wait out every awaited result, then the tail of the block's work
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (calm_sender) begin
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 49) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Run limit
	initial begin
		#10ms;
		$display("priority_evicting_event_buffer regression: fail");
		$finish;
	end

	initial begin
		int c;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = CMD_NONE;
		hold_off_req = 1'b0;
		calm_sender  = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty publish, field extremes, clamping, unused code
		issue(CMD_PUBLISH, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
		issue(CMD_RECORD, 8'h00, 16'h0000, 8'd0, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 0);
		issue(CMD_RECORD, 8'hFF, 16'hFFFF, 8'd1, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		issue(CMD_RECORD, 8'hA5, 16'h5A5A, 8'd2, 8'h5A, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		issue(CMD_RECORD, 8'h5A, 16'hA5A5, 8'd3, 8'hA5, 32'hFFFF_FFFF, 32'h0000_0000, 0);
		issue(CMD_RECORD, 8'h3C, 16'h1234, 8'd255, 8'h81, 32'h1, 32'h2, 0);
		issue(CMD_NONE, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, '1, '1, '1);
		issue(CMD_PUBLISH, 0, 0, 0, 0, 0, 0, 32'h0000_0000);
		issue(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		issue(CMD_PUBLISH, 0, 0, 0, 0, 0, 0, 32'h8000_0001);

		// Fill the store with level 1 and level 2 events, then force evictions and drops
		for (int i = 0; i < 32; i++)
			issue(CMD_RECORD, 8'(i), 16'(i * 7), 8'(1 + (i % 2)), 8'(i), $urandom,
			      $urandom, 0);
		issue(CMD_RECORD, 8'hEE, 16'hEEEE, 8'd0, 8'hEE, 0, 0, 0);
		issue(CMD_RECORD, 8'hDD, 16'hDDDD, 8'd2, 8'hDD, 0, 0, 0);
		issue(CMD_RECORD, 8'hCC, 16'hCCCC, 8'd2, 8'hCC, 0, 0, 0);
		issue(CMD_PUBLISH, 0, 0, 0, 0, 0, 0, 32'hDEAD_BEEF);

		// Long receiver hold-off while commands keep coming
		hold_off_req = 1'b1;
		for (int i = 0; i < 6; i++)
			random_event(i == 3 ? CMD_PUBLISH : CMD_RECORD);

		// Pause the sender until the block has delivered everything
		drain();

		// Random part, mostly records so the store stays full and evicts
		for (int n = 0; n < 220; n++) begin
			if (n % 60 == 30)
				calm_sender = 1'b1;
			if (n % 60 == 45)
				calm_sender = 1'b0;
			if (n == 110)
				drain();
			c = $urandom_range(0, 99);
			if (c < 76)
				random_event(CMD_RECORD);
			else if (c < 91)
				random_event(CMD_PUBLISH);
			else if (c < 96)
				random_event(CMD_CLEAR);
			else
				random_event(CMD_NONE);
		end
		calm_sender = 1'b0;
		issue(CMD_PUBLISH, 0, 0, 0, 0, 0, 0, $urandom);
		drain();
		repeat (300) @(posedge clk);
		u_checker.close_out();

		$display("covered %0d records, %0d publishes, %0d clears, %0d unused commands",
		         sent_by_cmd[CMD_RECORD], sent_by_cmd[CMD_PUBLISH],
		         sent_by_cmd[CMD_CLEAR], sent_by_cmd[CMD_NONE]);
		$display("store overflowed with %0d evictions under random back-pressure", evictions);
		if (fail_count == 0)
			$display("priority_evicting_event_buffer regression: pass");
		else
			$display("priority_evicting_event_buffer regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

>>> priority_evicting_event_buffer.f
src/pebuf_pkg.sv
src/pebuf_store.sv
src/priority_evicting_event_buffer.sv
test/pebuf_checker.sv
test/tb_priority_evicting_event_buffer.sv
